[design/dcsg_pkg.sv]
package dcsg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int INC_W    = 17;
    localparam int PHASE_W  = 18;
    localparam int SINE_W   = 17;
    localparam int TARGET_W = 16;
    localparam int XY_W     = 18;
    localparam int CUR_W    = 18;

    localparam logic [PHASE_W-1:0] PI2        = PHASE_W'(51471);
    localparam logic [PHASE_W-1:0] HALF_TURN  = PHASE_W'(2 * 51471);
    localparam logic [PHASE_W-1:0] THREE_PI2  = PHASE_W'(3 * 51471);
    localparam logic [PHASE_W-1:0] FULL_TURN  = PHASE_W'(4 * 51471);
    localparam logic signed [XY_W-1:0] START_X = XY_W'(19898);

    typedef struct packed {
        logic                       valid;
        logic signed [XY_W-1:0]     x;
        logic signed [XY_W-1:0]     y;
        logic signed [CUR_W-1:0]    cur;
        logic [TARGET_W-1:0]        target;
        logic                       negate;
        logic [PHASE_W-1:0]         phase;
    } t_cordic;

    function automatic logic signed [CUR_W-1:0] atan_q15(input int step);
        logic signed [CUR_W-1:0] a;
        case (step)
            0:       a = CUR_W'(25735);
            1:       a = CUR_W'(15192);
            2:       a = CUR_W'(8027);
            3:       a = CUR_W'(4074);
            4:       a = CUR_W'(2045);
            5:       a = CUR_W'(1023);
            6:       a = CUR_W'(511);
            7:       a = CUR_W'(255);
            8:       a = CUR_W'(127);
            9:       a = CUR_W'(63);
            10:      a = CUR_W'(31);
            11:      a = CUR_W'(15);
            12:      a = CUR_W'(7);
            13:      a = CUR_W'(3);
            14:      a = CUR_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[design/dcsg_phase_front.sv]
module dcsg_phase_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_accept,
    input  logic                          i_tick,
    input  logic                          i_cfg_wr_en,
    input  logic [dcsg_pkg::INC_W-1:0]    i_cfg_wr_data,
    output dcsg_pkg::t_cordic             o_stage
);
    import dcsg_pkg::*;

    logic [INC_W-1:0]    r_inc;
    logic [PHASE_W-1:0]  r_phase_acc;
    logic [PHASE_W-1:0]  n_phase_acc;
    logic                r_acc_valid;
    logic [PHASE_W:0]    s_sum;
    logic [PHASE_W:0]    s_sum_red;
    logic [PHASE_W-1:0]  s_fold;
    t_cordic             r_stage;
    t_cordic             n_stage;

    assign s_sum     = {1'b0, r_phase_acc} + {2'b00, r_inc};
    assign s_sum_red = s_sum - {1'b0, FULL_TURN};
    assign n_phase_acc = (s_sum > {1'b0, FULL_TURN}) ? s_sum_red[PHASE_W-1:0]
                                                     : s_sum[PHASE_W-1:0];

    always_comb begin
        if (r_phase_acc > THREE_PI2) begin
            s_fold = FULL_TURN - r_phase_acc;
        end else if (r_phase_acc > HALF_TURN) begin
            s_fold = r_phase_acc - HALF_TURN;
        end else if (r_phase_acc > PI2) begin
            s_fold = HALF_TURN - r_phase_acc;
        end else begin
            s_fold = r_phase_acc;
        end
        n_stage        = r_stage;
        n_stage.valid  = r_acc_valid;
        n_stage.x      = START_X;
        n_stage.y      = '0;
        n_stage.cur    = '0;
        n_stage.target = s_fold[TARGET_W-1:0];
        n_stage.negate = r_phase_acc > HALF_TURN;
        n_stage.phase  = r_phase_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= '0;
        end else if (i_cfg_wr_en) begin
            r_inc <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_acc_valid <= 1'b0;
        end else if (i_en) begin
            r_acc_valid <= i_accept && i_tick;
            if (i_accept && i_tick) begin
                r_phase_acc <= n_phase_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[design/dcsg_cordic_cell.sv]
module dcsg_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [dcsg_pkg::STEP_W-1:0]   i_step,
    input  dcsg_pkg::t_cordic             i_stage,
    output dcsg_pkg::t_cordic             o_stage
);
    import dcsg_pkg::*;

    t_cordic                  r_stage;
    t_cordic                  n_stage;
    logic signed [XY_W-1:0]   s_xs;
    logic signed [XY_W-1:0]   s_ys;
    logic signed [CUR_W-1:0]  s_atan;
    logic                     s_up;

    assign s_xs   = i_stage.x >>> i_step;
    assign s_ys   = i_stage.y >>> i_step;
    assign s_atan = atan_q15(int'(i_step));
    assign s_up   = $signed({{(CUR_W-TARGET_W){1'b0}}, i_stage.target}) > i_stage.cur;

    always_comb begin
        n_stage = i_stage;
        if (s_up) begin
            n_stage.x   = i_stage.x - s_ys;
            n_stage.y   = i_stage.y + s_xs;
            n_stage.cur = i_stage.cur + s_atan;
        end else begin
            n_stage.x   = i_stage.x + s_ys;
            n_stage.y   = i_stage.y - s_xs;
            n_stage.cur = i_stage.cur - s_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[design/dds_cordic_sine_generator_core.sv]
// From a tick's input transfer to o_valid: phase accumulator, quadrant fold,
//   CORDIC cells, output register. Throughput: one sample per cycle while the
//   skid stage is empty; each CORDIC cell takes a new item every cycle.
// Output register plus skid stage: a stalled result does not block new transfers
//   until the skid stage fills. Synchronous active-low reset clears the phase,
//   the phase increment and all valid flags; no clearing pass is needed.
module dds_cordic_sine_generator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_tick,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dcsg_pkg::SINE_W-1:0]   o_sine_value,
    output logic [dcsg_pkg::PHASE_W-1:0]         o_phase_value,
    input  logic                                 i_cfg_wr_en,
    input  logic [dcsg_pkg::INC_W-1:0]           i_cfg_wr_data
);
    import dcsg_pkg::*;

    t_cordic                   s_chain [0:CORDIC_STEPS];
    logic                      s_en;
    logic                      s_accept;
    logic                      s_new_valid;
    logic signed [XY_W-1:0]    s_neg_y;
    logic signed [SINE_W-1:0]  s_new_sine;

    logic                      r_out_valid;
    logic signed [SINE_W-1:0]  r_out_sine;
    logic [PHASE_W-1:0]        r_out_phase;
    logic                      r_skid_valid;
    logic signed [SINE_W-1:0]  r_skid_sine;
    logic [PHASE_W-1:0]        r_skid_phase;

    assign s_en     = !r_skid_valid;
    assign o_stall  = r_skid_valid;
    assign s_accept = i_valid && !r_skid_valid;

    dcsg_phase_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (s_en),
        .i_accept      (s_accept),
        .i_tick        (i_tick),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_stage       (s_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        dcsg_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_step  (STEP_W'(g)),
            .i_stage (s_chain[g]),
            .o_stage (s_chain[g+1])
        );
    end

    assign s_new_valid = s_en && s_chain[CORDIC_STEPS].valid;
    assign s_neg_y     = -s_chain[CORDIC_STEPS].y;
    assign s_new_sine  = s_chain[CORDIC_STEPS].negate ? s_neg_y[SINE_W-1:0]
                                                      : s_chain[CORDIC_STEPS].y[SINE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out_sine   <= r_skid_sine;
                r_out_phase  <= r_skid_phase;
                r_skid_valid <= 1'b0;
            end
        end else if (s_new_valid) begin
            if (r_out_valid && i_stall) begin
                r_skid_sine  <= s_new_sine;
                r_skid_phase <= s_chain[CORDIC_STEPS].phase;
                r_skid_valid <= 1'b1;
            end else begin
                r_out_sine  <= s_new_sine;
                r_out_phase <= s_chain[CORDIC_STEPS].phase;
                r_out_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sine_value  = r_out_sine;
    assign o_phase_value = r_out_phase;

endmodule
